FILE: sv/sha256_byte_stream_hash_top_assert.svh
// Assertion macros shared by the hash block.
`ifndef SHA256_BYTE_STREAM_HASH_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define S256_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("s256 assertion failed");

// Condition that must never be true outside reset.
`define S256_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("s256 forbidden condition seen");

`else

`define S256_ASSERT(lbl, clk, rst_n, prop)
`define S256_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/s256_pkg.sv
`default_nettype none

package s256_pkg;

  typedef logic [31:0] word_t;
  // Working variables a..h, index 0 is a.
  typedef word_t [7:0] work_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // Controls from the sequencer to the message schedule
  typedef struct packed {
    logic       load;      // take one byte into the block
    logic [7:0] byte_val;
    logic       word_end;  // byte completes a 32-bit word
    logic       expand;    // advance schedule by one round
  } sched_ctl_t;

  localparam logic       OP_ABSORB = 1'b0;
  localparam logic       OP_FINISH = 1'b1;
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Round sigmas
  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Schedule sigmas
  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/s256_stream_if.sv
`default_nettype none

interface s256_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/s256_round.sv
`default_nettype none

// One compression round; the single arithmetic unit reused for all 64 rounds.
module s256_round (
  input  s256_pkg::work_t v_i,
  input  s256_pkg::word_t k_i,
  input  s256_pkg::word_t w_i,
  output s256_pkg::work_t v_o
);

  s256_pkg::word_t ch;
  s256_pkg::word_t maj;
  s256_pkg::word_t t1;
  s256_pkg::word_t t2;

  always_comb begin
    ch  = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1  = v_i[7] + s256_pkg::bsig1(v_i[4]) + ch + k_i + w_i;
    t2  = s256_pkg::bsig0(v_i[0]) + maj;
  end

  // Rotate the working variables
  always_comb begin
    v_o[0] = t1 + t2;
    v_o[1] = v_i[0];
    v_o[2] = v_i[1];
    v_o[3] = v_i[2];
    v_o[4] = v_i[3] + t1;
    v_o[5] = v_i[4];
    v_o[6] = v_i[5];
    v_o[7] = v_i[6];
  end

endmodule

`default_nettype wire

FILE: sv/s256_sched.sv
`default_nettype none

// Block buffer and message schedule as one 16-word shift line.
// Bytes pack into words that shift in at the top; during rounds the
// line slides by one word, tap 0 being the current round word.
module s256_sched (
  input  wire                    clk_i,
  input  s256_pkg::sched_ctl_t   ctl_i,
  output s256_pkg::word_t        w_o
);

  logic [23:0]        acc_q;
  logic [15:0][31:0]  line_q;
  s256_pkg::word_t    nxt_w;

  // Next schedule word from the fixed taps
  assign nxt_w = s256_pkg::ssig1(line_q[14]) + line_q[9]
               + s256_pkg::ssig0(line_q[1]) + line_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      acc_q <= {acc_q[15:0], ctl_i.byte_val};
      if (ctl_i.word_end) begin
        line_q <= {{acc_q, ctl_i.byte_val}, line_q[15:1]};
      end
    end else if (ctl_i.expand) begin
      line_q <= {nxt_w, line_q[15:1]};
    end
  end

  assign w_o = line_q[0];

endmodule

`default_nettype wire

FILE: sv/sha256_byte_stream_hash_top.sv
`default_nettype none
// Channel  Dir  Payload                              Accepted when
// in_i     in   op, data_byte                        in_i.valid && in_i.ready
// out_o    out  digest_word, word_index, last_word   out_o.valid && out_o.ready
//
// An absorb transaction is taken while idle; the 64th byte of a block starts 64 rounds
// of the shared round unit plus one chaining add, and no further byte is taken until
// they complete. A finish feeds the padding bytes through the same
// byte path (one per cycle, 64 - pos or 128 - pos of them), runs one or two
// compressions and then presents eight digest words, one per cycle unless stalled.
// Reset loads the initial hash values and clears the byte count; no sweep.
// in_i.ready is high only while idle; out_o stalls hold the current word.

`include "sha256_byte_stream_hash_top_assert.svh"

module sha256_byte_stream_hash_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  s256_stream_if.sink         in_i,
  s256_stream_if.source       out_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [60:0]            tot_q, tot_d;
  logic [63:0]            bits_q, bits_d;
  logic                   fin_q, fin_d;         // finishing a message
  logic                   first_q, first_d;     // next pad byte is the marker
  logic                   fin_blk_q, fin_blk_d; // current pad block takes the length
  logic [5:0]             rnd_q, rnd_d;
  logic [2:0]             widx_q, widx_d;
  s256_pkg::word_t        h_q [8];
  s256_pkg::word_t        h_d [8];
  s256_pkg::work_t        v_q, v_d, v_rnd;
  s256_pkg::work_t        h_pack;
  s256_pkg::sched_ctl_t   sctl;
  s256_pkg::word_t        w_cur;
  s256_pkg::in_t          in_data;
  logic [5:0]             pos;
  logic [7:0]             pad_byte;
  logic                   in_acc;
  logic                   out_acc;

  assign in_data = in_i.data;
  assign pos     = tot_q[5:0];
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Padding byte: marker, then zeros, then the bit length big-endian
  always_comb begin
    if (first_q) begin
      pad_byte = s256_pkg::PAD_MARK;
    end else if (fin_blk_q && (pos[5:3] == 3'b111)) begin
      pad_byte = bits_q[{~pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_pack[i] = h_q[i];
    end
  end

  s256_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sctl),
    .w_o   (w_cur)
  );

  s256_round u_round (
    .v_i (v_q),
    .k_i (s256_pkg::K[rnd_q]),
    .w_i (w_cur),
    .v_o (v_rnd)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    tot_d     = tot_q;
    bits_d    = bits_q;
    fin_d     = fin_q;
    first_d   = first_q;
    fin_blk_d = fin_blk_q;
    rnd_d     = rnd_q;
    widx_d    = widx_q;
    v_d       = v_q;
    for (int i = 0; i < 8; i++) begin
      h_d[i] = h_q[i];
    end
    sctl.load     = 1'b0;
    sctl.byte_val = in_data.data_byte;
    sctl.word_end = (pos[1:0] == 2'b11);
    sctl.expand   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op == s256_pkg::OP_ABSORB) begin
            sctl.load = 1'b1;
          end else begin
            bits_d    = {tot_q, 3'b000};
            fin_d     = 1'b1;
            first_d   = 1'b1;
            fin_blk_d = (pos[5:3] != 3'b111);
            state_d   = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sctl.load     = 1'b1;
        sctl.byte_val = pad_byte;
        first_d       = 1'b0;
      end
      ST_COMP: begin
        sctl.expand = 1'b1;
        v_d   = v_rnd;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == s256_pkg::LAST_POS) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (fin_blk_q) begin
          widx_d  = 3'd0;
          state_d = ST_OUT;
        end else begin
          fin_blk_d = 1'b1;
          state_d   = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == s256_pkg::LAST_WORD) begin
            for (int i = 0; i < 8; i++) begin
              h_d[i] = s256_pkg::IV[i];
            end
            tot_d   = '0;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Byte into the block; a full block starts the rounds
    if (sctl.load) begin
      tot_d = tot_q + 61'd1;
      if (pos == s256_pkg::LAST_POS) begin
        v_d     = h_pack;
        rnd_d   = 6'd0;
        state_d = ST_COMP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tot_q     <= '0;
      fin_q     <= 1'b0;
      first_q   <= 1'b0;
      fin_blk_q <= 1'b0;
      rnd_q     <= '0;
      widx_q    <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= s256_pkg::IV[i];
      end
    end else begin
      state_q   <= state_d;
      tot_q     <= tot_d;
      fin_q     <= fin_d;
      first_q   <= first_d;
      fin_blk_q <= fin_blk_d;
      rnd_q     <= rnd_d;
      widx_q    <= widx_d;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_d[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    v_q    <= v_d;
  end

  // Digest words come straight from the chaining registers
  assign out_o.valid            = (state_q == ST_OUT);
  assign out_o.data.digest_word = h_q[widx_q];
  assign out_o.data.word_index  = widx_q;
  assign out_o.data.last_word   = (widx_q == s256_pkg::LAST_WORD);

  // Checks
  `S256_NEVER(a_ready_while_out, clk_i, rst_ni, in_i.ready && out_o.valid)
  `S256_ASSERT(a_out_after_add, clk_i, rst_ni, $rose(out_o.valid) |-> $past(state_q) == ST_ADD)
  `S256_ASSERT(a_out_block_aligned, clk_i, rst_ni, out_o.valid |-> tot_q[5:0] == 6'd0)
  `S256_ASSERT(a_last_back_idle, clk_i, rst_ni, (out_acc && out_o.data.last_word) |=> in_i.ready)

endmodule

`default_nettype wire

FILE: verif/sha256_digest_monitor.sv
`timescale 1ns / 1ps

// Watches both channels of the hash block, tracks the message in a local
// SHA-256 model and compares every digest word against the predicted one.
module sha256_digest_monitor
  import s256_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   err_count_o,
  output int   pending_o
);

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         LEN_POS    = 56;   // first byte of the length field
  localparam int         BLOCK_LAST = 63;
  localparam int         WORD_LAST  = 7;

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Model state: chaining words, message length in bytes, block buffer
  logic [31:0] chain_h [8];
  logic [60:0] byte_count;
  logic [7:0]  block_bytes [64];

  // Digest words predicted but not yet seen on the output
  out_t want_words [$];

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain_h[i] = START_H[i];
    byte_count = '0;
    for (int i = 0; i < 64; i++) block_bytes[i] = '0;
  endfunction

  // One 64-round compression of the buffer into the chaining words
  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, a, e;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      a  = v[0];
      e  = v[4];
      t1 = v[7] + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) +
           ((e & v[5]) ^ (~e & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) +
           ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    logic [5:0] pos;
    pos = byte_count[5:0];
    block_bytes[pos] = b;
    byte_count = byte_count + 61'd1;   // wraps at 2^61
    if (int'(pos) == BLOCK_LAST) hash_block();
  endfunction

  // Pad, append the bit length, compress and queue the eight digest words
  function automatic void finish_message();
    logic [63:0] bit_len;
    int          p;
    out_t        word;
    bit_len = {byte_count, 3'b000};
    block_bytes[byte_count[5:0]] = PAD_BYTE;
    p = int'(byte_count[5:0]) + 1;
    // no room left for the length field: an extra block goes first
    if (p > LEN_POS) begin
      for (int i = p; i <= BLOCK_LAST; i++) block_bytes[i] = '0;
      hash_block();
      p = 0;
    end
    for (int i = p; i < LEN_POS; i++) block_bytes[i] = '0;
    for (int i = 0; i < 8; i++) block_bytes[BLOCK_LAST - i] = bit_len[8*i +: 8];
    hash_block();
    for (int k = 0; k <= WORD_LAST; k++) begin
      word.digest_word = chain_h[k];
      word.word_index  = 3'(k);
      word.last_word   = (k == WORD_LAST);
      want_words.push_back(word);
    end
    restart_message();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    err_count_o++;
  endtask

  // Compare output transactions first, then feed input transactions to the model
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      restart_message();
      want_words.delete();
      err_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (want_words.size() == 0) begin
          report_mismatch($sformatf("digest word %h index %0d with nothing expected",
                                    out_data_i.digest_word, out_data_i.word_index));
        end else begin
          want = want_words.pop_front();
          if (out_data_i.digest_word !== want.digest_word)
            report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                      out_data_i.digest_word, want.digest_word,
                                      want.word_index));
          if (out_data_i.word_index !== want.word_index)
            report_mismatch($sformatf("word_index %0d, expected %0d",
                                      out_data_i.word_index, want.word_index));
          if (out_data_i.last_word !== want.last_word)
            report_mismatch($sformatf("last_word %b, expected %b (index %0d)",
                                      out_data_i.last_word, want.last_word,
                                      want.word_index));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.op == OP_FINISH) finish_message();
        else take_byte(in_data_i.data_byte);
      end
    end
    pending_o = want_words.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import s256_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 100;

  logic clk_i;
  logic rst_ni;

  s256_stream_if #(.payload_t(in_t))  in_if ();
  s256_stream_if #(.payload_t(out_t)) out_if ();

  int err_count;
  int pending;
  int items_sent    = 0;
  int finishes_sent = 0;
  int cycle_count   = 0;
  bit calm_phase    = 1'b0;   // no idling on either side once set

  sha256_byte_stream_hash_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sha256_digest_monitor digest_mon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Output stalls in random bursts
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic op, input logic [7:0] b);
    in_t item;
    item.op        = op;
    item.data_byte = b;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (op == OP_FINISH) finishes_sent++;
  endtask

  // Random message of len bytes, then finish (its data byte is don't-care)
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int bound_len [4];
    int j, tmp, len;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_ni      <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, "abc", byte extremes, empty again
    send_item(OP_FINISH, 8'hff);
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_FINISH, 8'h5a);
    send_item(OP_FINISH, 8'ha5);

    // Padding boundaries: marker at 55 fits, at 56 and 63 needs an extra
    // block, and a full block pads into a fresh one; shuffled order
    bound_len = '{55, 56, 63, 64};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = bound_len[i];
      bound_len[i] = bound_len[j];
      bound_len[j] = tmp;
    end
    for (int i = 0; i < 4; i++) send_message(bound_len[i]);

    // Mostly short messages, some spanning two or three blocks
    while (items_sent < 250 || finishes_sent < 9) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(65, 130);
      else len = $urandom_range(0, 12);
      send_message(len);
    end

    // Tail at full rate on both sides
    calm_phase = 1'b1;
    send_message($urandom_range(57, 70));
    send_message($urandom_range(0, 8));
    in_if.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sha256_byte_stream_hash_top.f
+incdir+sv
sv/s256_pkg.sv
sv/s256_stream_if.sv
sv/s256_round.sv
sv/s256_sched.sv
sv/sha256_byte_stream_hash_top.sv
verif/sha256_digest_monitor.sv
verif/testbench.sv
